FILE: src/hris_pkg.sv
// Shared types and constants for the HID report idle scheduler.
package hris_pkg;

  localparam int REPORT_W  = 64;
  localparam int IDLE_MS_W = 10;

  localparam logic [IDLE_MS_W-1:0] IDLE_RESET_MS = 10'd500;
  localparam logic [7:0]           REQ_GET       = 8'hA1;
  localparam logic [7:0]           REQ_SET       = 8'h21;

  typedef enum logic [2:0] {
    FUNC_PUSH       = 3'd0,
    FUNC_TICK       = 3'd1,
    FUNC_POLL       = 3'd2,
    FUNC_SET_IDLE   = 3'd3,
    FUNC_GET_IDLE   = 3'd4,
    FUNC_GET_REPORT = 3'd5
  } func_t;

  typedef enum logic [1:0] {
    KIND_NONE      = 2'd0,
    KIND_INTERRUPT = 2'd1,
    KIND_CONTROL   = 2'd2,
    KIND_IDLE_CODE = 2'd3
  } kind_t;

  typedef struct packed {
    logic push;
    logic pop;
  } fifo_ctl_t;

  typedef struct packed {
    logic empty;
    logic full;
  } fifo_sts_t;

endpackage

FILE: src/hris_fifo.sv
// Report queue with a registered head entry.
module hris_fifo #(
  parameter int DEPTH = 8
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  hris_pkg::fifo_ctl_t             ctl,
  input  logic [hris_pkg::REPORT_W-1:0]   wr_data,
  output hris_pkg::fifo_sts_t             sts,
  output logic [hris_pkg::REPORT_W-1:0]   head
);
  import hris_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [REPORT_W-1:0] mem [DEPTH];
  logic [AW-1:0]       wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]       rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]       count_r, count_nxt;
  logic [REPORT_W-1:0] head_r;

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    ptr_inc = (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
  endfunction

  always_comb begin
    wr_ptr_nxt = ctl.push ? ptr_inc(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = ctl.pop  ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    count_nxt  = count_r;
    if (ctl.push && !ctl.pop) begin
      count_nxt = count_r + CW'(1);
    end else if (ctl.pop && !ctl.push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Keep head_r equal to the entry at the read pointer; bypass a write into an empty queue.
  always_ff @(posedge clk) begin
    if (ctl.push) begin
      mem[wr_ptr_r] <= wr_data;
    end
    if (ctl.push && (wr_ptr_r == rd_ptr_nxt)) begin
      head_r <= wr_data;
    end else begin
      head_r <= mem[rd_ptr_nxt];
    end
  end

  assign sts.empty = (count_r == '0);
  assign sts.full  = (count_r == CW'(DEPTH));
  assign head      = head_r;

endmodule

FILE: src/hris_ctrl.sv
// Function decode, idle countdown and last-report state.
module hris_ctrl (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            fire,
  input  hris_pkg::func_t                 func,
  input  logic [hris_pkg::REPORT_W-1:0]   report_in,
  input  logic [7:0]                      request_type,
  input  logic [7:0]                      idle_value,
  input  logic                            in_ready,
  input  hris_pkg::fifo_sts_t             fifo_sts,
  input  logic [hris_pkg::REPORT_W-1:0]   fifo_head,
  output hris_pkg::fifo_ctl_t             fifo_ctl,
  output logic [hris_pkg::REPORT_W-1:0]   fifo_wr_data,
  output hris_pkg::kind_t                 res_kind,
  output logic [hris_pkg::REPORT_W-1:0]   res_report,
  output logic [7:0]                      res_code,
  output logic                            res_drop
);
  import hris_pkg::*;

  logic [REPORT_W-1:0]  last_report_r, last_report_nxt;
  logic [IDLE_MS_W-1:0] idle_ms_r, idle_ms_nxt;
  logic [IDLE_MS_W-1:0] idle_left_r, idle_left_nxt;
  logic                 send;

  assign fifo_wr_data = report_in;

  always_comb begin
    last_report_nxt = last_report_r;
    idle_ms_nxt     = idle_ms_r;
    idle_left_nxt   = idle_left_r;
    fifo_ctl        = '0;
    res_kind        = KIND_NONE;
    res_report      = '0;
    res_code        = '0;
    res_drop        = 1'b0;
    send            = 1'b0;
    unique case (func)
      FUNC_PUSH: begin
        if (fifo_sts.full) begin
          res_drop = 1'b1;
        end else begin
          fifo_ctl.push = fire;
        end
      end
      FUNC_TICK: begin
        if (idle_left_r != '0) begin
          idle_left_nxt = idle_left_r - IDLE_MS_W'(1);
        end
      end
      FUNC_POLL: begin
        if (in_ready) begin
          if (!fifo_sts.empty) begin
            fifo_ctl.pop = fire;
            if (fifo_head != last_report_r) begin
              last_report_nxt = fifo_head;
              send            = 1'b1;
            end
          end
          // Idle of zero disables the timed resend
          if ((idle_ms_r != '0) && (idle_left_r == '0)) begin
            send = 1'b1;
          end
          if (send) begin
            res_kind      = KIND_INTERRUPT;
            res_report    = last_report_nxt;
            idle_left_nxt = idle_ms_r;
          end
        end
      end
      FUNC_SET_IDLE: begin
        if (request_type == REQ_SET) begin
          idle_ms_nxt = {idle_value, 2'b00};
        end
      end
      FUNC_GET_IDLE: begin
        if (request_type == REQ_GET) begin
          res_kind = KIND_IDLE_CODE;
          res_code = idle_ms_r[IDLE_MS_W-1:2];
        end
      end
      FUNC_GET_REPORT: begin
        if (request_type == REQ_GET) begin
          res_kind   = KIND_CONTROL;
          res_report = last_report_r;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_report_r <= '0;
      idle_ms_r     <= IDLE_RESET_MS;
      idle_left_r   <= '0;
    end else if (fire) begin
      last_report_r <= last_report_nxt;
      idle_ms_r     <= idle_ms_nxt;
      idle_left_r   <= idle_left_nxt;
    end
  end

endmodule

FILE: src/hid_report_idle_scheduler.sv
// Top level of the HID report idle scheduler: input register, control, queue, result register.
//
//   channel | dir | tdata (low bit up)                                    | tuser
//   in_     | in  | report_in[63:0] request_type[71:64] idle_value[79:72] | func[2:0]
//           |     | in_ready[80], zero pad to 88                          |
//   out_    | out | report_out[63:0] idle_code[71:64] dropped[72],        | result_kind[1:0]
//           |     | zero pad to 80                                        |
//
// One item per cycle while out_tready holds; each accepted item gives exactly one result.
// The item is processed as it moves from the input register into the result register.
// Reset clears the queue pointers, the countdown, the last report and sets idle to 500 ms.
// With the result register full and out_tready low, an item in the input register holds there and
// in_tready drops.
module hid_report_idle_scheduler #(
  parameter int FIFO_DEPTH = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [87:0] in_tdata,   // report_in, request_type, idle_value, in_ready
  input  logic [2:0]  in_tuser,   // func
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [79:0] out_tdata,  // report_out, idle_code, dropped
  output logic [1:0]  out_tuser   // result_kind
);
  import hris_pkg::*;

  logic                s1_valid_r;
  func_t               s1_func_r;
  logic [REPORT_W-1:0] s1_report_r;
  logic [7:0]          s1_req_r;
  logic [7:0]          s1_idle_r;
  logic                s1_ready_r;
  logic                s1_fire;

  logic                out_valid_r;
  logic [79:0]         out_tdata_r;
  logic [1:0]          out_tuser_r;

  fifo_ctl_t           fifo_ctl;
  fifo_sts_t           fifo_sts;
  logic [REPORT_W-1:0] fifo_head;
  logic [REPORT_W-1:0] fifo_wr_data;
  kind_t               res_kind;
  logic [REPORT_W-1:0] res_report;
  logic [7:0]          res_code;
  logic                res_drop;

  assign s1_fire   = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_func_r   <= func_t'(in_tuser);
      s1_report_r <= in_tdata[63:0];
      s1_req_r    <= in_tdata[71:64];
      s1_idle_r   <= in_tdata[79:72];
      s1_ready_r  <= in_tdata[80];
    end
  end

  hris_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .fire         (s1_fire),
    .func         (s1_func_r),
    .report_in    (s1_report_r),
    .request_type (s1_req_r),
    .idle_value   (s1_idle_r),
    .in_ready     (s1_ready_r),
    .fifo_sts     (fifo_sts),
    .fifo_head    (fifo_head),
    .fifo_ctl     (fifo_ctl),
    .fifo_wr_data (fifo_wr_data),
    .res_kind     (res_kind),
    .res_report   (res_report),
    .res_code     (res_code),
    .res_drop     (res_drop)
  );

  hris_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (fifo_ctl),
    .wr_data (fifo_wr_data),
    .sts     (fifo_sts),
    .head    (fifo_head)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_tdata_r <= {7'd0, res_drop, res_code, res_report};
      out_tuser_r <= res_kind;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

endmodule
